### hdl/lsfb_pkg.sv
// Shared types, constants and a helper function for the LED string frame builder.
package lsfb_pkg;

  // One LED item as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_item_t;

  // One byte for the serial link.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } link_byte_t;

  // Frame mode codes; the spare code behaves as grayscale.
  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_DOT  = 2'd1;
  localparam logic [1:0] MODE_CFG  = 2'd2;

  // Preamble headers per mode.
  localparam logic [5:0] HDR_GRAY = 6'h3F;
  localparam logic [5:0] HDR_DOT  = 6'h33;
  localparam logic [5:0] HDR_CFG  = 6'h23;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_STRING_LEN = 2'd0;
  localparam logic [1:0] REG_FRAME_MODE = 2'd1;
  localparam logic [1:0] REG_SETUP_ONE = 2'd2;
  localparam logic [1:0] REG_SETUP_TWO = 2'd3;

  localparam int JOB_BYTES     = 12;
  localparam int PAYLOAD_BYTES = 6;

  typedef struct packed {
    logic [9:0] string_len;
    logic [1:0] frame_mode;
    logic [9:0] setup_word_one;
    logic [2:0] setup_word_two;
  } frame_cfg_t;

  // Bytes of one LED, preamble first where present; byte 0 goes out first.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic                      with_preamble;
    logic                      frame_end;
  } frame_job_t;

  typedef struct packed {
    logic busy;
    logic at_end;
  } ser_status_t;

  function automatic logic parity10(input logic [9:0] v);
    return ^v;
  endfunction

endpackage

### hdl/lsfb_format.sv
// Formatting stage: builds the preamble and payload bytes of one LED and tracks the LED position.
module lsfb_format import lsfb_pkg::*; #(
  parameter int COUNT_BITS = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  frame_cfg_t cfg,
  input  led_item_t  item,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic       job_take,
  output frame_job_t job,
  output logic       job_valid
);

  localparam logic [9:0] CountMask = 10'((1 << COUNT_BITS) - 1);

  logic [9:0]  led_position;
  logic [9:0]  led_position_next;
  logic        accept;
  logic [9:0]  last_pos;
  logic        is_last;
  logic [9:0]  count;
  logic [5:0]  header;
  logic [3:0]  par;
  logic [15:0] word0;
  logic [15:0] word1;
  logic [15:0] word2;
  logic [15:0] setup_one;
  logic [PAYLOAD_BYTES-1:0][7:0] payload;
  frame_job_t  job_next;

  assign item_ready = !job_valid || job_take;
  assign accept     = item_valid && item_ready;

  always_comb begin
    last_pos = cfg.string_len - 10'd1;
    is_last  = (led_position >= last_pos);
    led_position_next = is_last ? 10'd0 : led_position + 10'd1;

    case (cfg.frame_mode)
      MODE_DOT: begin
        header = HDR_DOT;
        count  = last_pos & CountMask;
      end
      MODE_CFG: begin
        header = HDR_CFG;
        count  = cfg.string_len & CountMask;
      end
      default: begin
        header = HDR_GRAY;
        count  = last_pos & CountMask;
      end
    endcase

    par[0] = parity10(count);
    par[1] = 1'b0;
    par[2] = ^header;
    par[3] = par[0] ^ par[2];
    word0 = {header, 10'd0};
    word1 = {header, count};
    word2 = {par, 2'b00, count};
    setup_one = {6'd0, cfg.setup_word_one};

    case (cfg.frame_mode)
      MODE_DOT: begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) payload[i] = 8'hFF;
      end
      MODE_CFG: begin
        payload[0] = setup_one[15:8];
        payload[1] = setup_one[7:0];
        payload[2] = setup_one[15:8];
        payload[3] = setup_one[7:0];
        payload[4] = 8'h00;
        payload[5] = {5'd0, cfg.setup_word_two};
      end
      default: begin
        payload[0] = item.red;
        payload[1] = 8'h00;
        payload[2] = item.green;
        payload[3] = 8'h00;
        payload[4] = item.blue;
        payload[5] = 8'h00;
      end
    endcase

    job_next = '0;
    job_next.frame_end     = is_last;
    job_next.with_preamble = (led_position == 10'd0);
    if (led_position == 10'd0) begin
      job_next.bytes[0] = word0[15:8];
      job_next.bytes[1] = word0[7:0];
      job_next.bytes[2] = word1[15:8];
      job_next.bytes[3] = word1[7:0];
      job_next.bytes[4] = word2[15:8];
      job_next.bytes[5] = word2[7:0];
      for (int i = 0; i < PAYLOAD_BYTES; i++) job_next.bytes[PAYLOAD_BYTES + i] = payload[i];
    end else begin
      for (int i = 0; i < PAYLOAD_BYTES; i++) job_next.bytes[i] = payload[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid    <= 1'b0;
      led_position <= 10'd0;
    end else if (accept) begin
      job_valid    <= 1'b1;
      led_position <= led_position_next;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

### hdl/lsfb_serial.sv
// Byte serialiser: holds one LED's bytes and sends them out one per transfer.
module lsfb_serial import lsfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  frame_job_t  job,
  input  logic        job_valid,
  output logic        job_take,
  output link_byte_t  link,
  output logic        link_valid,
  input  logic        link_ready,
  output ser_status_t status
);

  localparam int IdxBits = $clog2(JOB_BYTES);
  localparam logic [IdxBits-1:0] LastLong  = IdxBits'(JOB_BYTES - 1);
  localparam logic [IdxBits-1:0] LastShort = IdxBits'(PAYLOAD_BYTES - 1);

  logic                      busy;
  logic [IdxBits-1:0]        idx;
  logic [JOB_BYTES-1:0][7:0] buffer;
  logic                      with_preamble;
  logic                      frame_end;
  logic                      at_end;

  assign at_end   = (idx == (with_preamble ? LastLong : LastShort));
  assign job_take = job_valid && (!busy || (link_ready && at_end));

  assign link_valid     = busy;
  assign link.out_byte  = buffer[idx];
  assign link.frame_end = frame_end && at_end;
  assign status.busy    = busy;
  assign status.at_end  = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (job_take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && link_ready) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      buffer        <= job.bytes;
      with_preamble <= job.with_preamble;
      frame_end     <= job.frame_end;
    end
  end

endmodule

### hdl/led_string_frame_builder.sv
// Top level of the LED string frame builder: configuration registers, formatter and serialiser.
// The first byte of an LED passes through the formatter's job register and the serialiser's
// byte buffer before it is offered on the link.
// Throughput: six link bytes per LED, twelve for the first LED of a frame, sent by the
// serialiser one per cycle while link_ready is high; the formatter takes a new LED every cycle
// whenever its single job register is free or being emptied.
// Reset (rst, synchronous) empties both stages, restarts the frame and loads default registers.
module led_string_frame_builder import lsfb_pkg::*; #(
  parameter int COUNT_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  led_item_t   led,
  input  logic        led_valid,
  output logic        led_ready,
  output link_byte_t  link,
  output logic        link_valid,
  input  logic        link_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The configuration registers. They must be written only while the block is idle (the block
  // does not enforce it), so the formatter may read them directly when an LED is taken.
  logic [9:0]  string_len;
  logic [1:0]  frame_mode;
  logic [9:0]  setup_word_one;
  logic [2:0]  setup_word_two;
  frame_cfg_t  cfg;
  logic        reg_write;
  logic [1:0]  reg_index;

  frame_job_t  job;
  logic        job_valid;
  logic        job_take;
  ser_status_t ser_status;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      string_len     <= 10'd40;
      frame_mode     <= MODE_GRAY;
      setup_word_one <= 10'd878;
      setup_word_two <= 3'd7;
    end else if (reg_write) begin
      unique case (reg_index)
        REG_STRING_LEN: string_len     <= pwdata[9:0];
        REG_FRAME_MODE: frame_mode     <= pwdata[1:0];
        REG_SETUP_ONE:  setup_word_one <= pwdata[9:0];
        REG_SETUP_TWO:  setup_word_two <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read-back is a plain decode of the word address.
  always_comb begin
    unique case (reg_index)
      REG_STRING_LEN: prdata = {22'd0, string_len};
      REG_FRAME_MODE: prdata = {30'd0, frame_mode};
      REG_SETUP_ONE:  prdata = {22'd0, setup_word_one};
      REG_SETUP_TWO:  prdata = {29'd0, setup_word_two};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg = '{string_len:     string_len,
                 frame_mode:     frame_mode,
                 setup_word_one: setup_word_one,
                 setup_word_two: setup_word_two};

  // The formatter turns one LED transfer into a complete job of six or twelve bytes in a
  // single registered pass, and keeps the position of the next LED in the frame.
  lsfb_format #(
    .COUNT_BITS(COUNT_BITS)
  ) u_format (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (led),
    .item_valid (led_valid),
    .item_ready (led_ready),
    .job_take   (job_take),
    .job        (job),
    .job_valid  (job_valid)
  );

  // The serialiser takes the waiting job as soon as its last byte transfer completes, so
  // bytes of consecutive LEDs follow without a gap.
  lsfb_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .job_valid  (job_valid),
    .job_take   (job_take),
    .link       (link),
    .link_valid (link_valid),
    .link_ready (link_ready),
    .status     (ser_status)
  );

  // A job that is not taken must still be waiting in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_take |=> job_valid)
    else $error("formatter job lost before the serialiser took it");

  // An accepted LED always leaves a job behind.
  assert property (@(posedge clk) disable iff (rst)
    led_valid && led_ready |=> job_valid)
    else $error("accepted LED produced no job");

  // The frame end mark may only sit on the last byte of a job.
  assert property (@(posedge clk) disable iff (rst)
    link_valid && link.frame_end |-> ser_status.at_end)
    else $error("frame end marked on a byte other than the last of an LED");

  // The serialiser only takes a job once the previous one has fully gone out.
  assert property (@(posedge clk) disable iff (rst)
    job_take && ser_status.busy |-> link_ready && ser_status.at_end)
    else $error("serialiser overwrote a job still being sent");

endmodule
